[design/sesp_pkg.sv]
// Shared types and constants for the sequence event stream parser.
package sesp_pkg;

	localparam int SEEK_W      = 20;
	localparam int TICK_W      = 32;
	localparam int TEMPO_W     = 24;
	localparam int BEND_W      = 14;
	localparam int DELTA_W     = 28;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic CMD_FEED    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
	localparam logic [3:0] ST_NOTE_ON    = 4'h9;
	localparam logic [3:0] ST_CONTROL    = 4'hB;
	localparam logic [3:0] ST_PROGRAM    = 4'hC;
	localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
	localparam logic [3:0] ST_BEND       = 4'hE;

	localparam logic [7:0] STATUS_SYS    = 8'hF0;
	localparam logic [7:0] STATUS_META   = 8'hFF;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_EOT      = 8'h2F;
	localparam logic [7:0] CC_LOOP_COUNT = 8'd6;
	localparam logic [7:0] CC_LOOP_MARK  = 8'd99;
	localparam logic [7:0] MARK_START    = 8'd20;
	localparam logic [7:0] MARK_END      = 8'd30;
	localparam logic [7:0] LOOP_FOREVER  = 8'd127;

	localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT   = 24'd500000;
	localparam logic [2:0]         DELTA_MAX_BYTES = 3'd4;

	typedef enum logic [3:0] {
		PH_DELTA  = 4'd0,
		PH_STATUS = 4'd1,
		PH_DATA1  = 4'd2,
		PH_DATA2  = 4'd3,
		PH_META   = 4'd4,
		PH_TEMPO1 = 4'd5,
		PH_TEMPO2 = 4'd6,
		PH_TEMPO3 = 4'd7,
		PH_EOTLEN = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		EV_NOTE_OFF   = 4'd0,
		EV_NOTE_ON    = 4'd1,
		EV_CONTROL    = 4'd2,
		EV_PROGRAM    = 4'd3,
		EV_BEND       = 4'd4,
		EV_TEMPO      = 4'd5,
		EV_LOOPBACK   = 4'd6,
		EV_END        = 4'd7,
		EV_RANOUT     = 4'd8,
		EV_BAD_STATUS = 4'd9,
		EV_DESYNC     = 4'd10
	} event_kind_t;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
		logic       last_byte;
	} feed_t;

	typedef struct packed {
		logic [3:0]         event_kind;
		logic [3:0]         channel;
		logic [7:0]         data_first;
		logic [7:0]         data_second;
		logic [BEND_W-1:0]  bend_value;
		logic [TICK_W-1:0]  delta_ticks;
		logic [TEMPO_W-1:0] tempo_us;
		logic [SEEK_W-1:0]  seek_position;
		logic               last_result;
	} res_t;

	typedef struct packed {
		logic two;
		res_t res_a;
		res_t res_b;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[design/seq_event_stream_parser_unit.sv]
// Sequence track event parser: top level joining front end, queue and back end.
// Path: a byte's first result is written to the queue, then loaded into the output register;
// a second result from the same byte is offered in the cycle after the first is taken.
// Throughput: one byte per cycle while the queue is not full; a byte with two results holds
// the output register for both; a run of such bytes fills the four-entry queue, stalling input.
// Reset: arst_n clears parse state, queue and output; a restart command clears parse state.
module seq_event_stream_parser_unit import sesp_pkg::*; #(
	parameter int POSITION_BITS = 20
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  feed_valid,
	output logic  feed_ready,
	input  feed_t feed_data,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res_data
);

	queue_status_t q_stat;
	logic          push, pop;
	bundle_t       push_data, pop_data;

	sesp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed_valid(feed_valid),
		.feed_ready(feed_ready),
		.feed_data (feed_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	sesp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	sesp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (pop_data),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

endmodule

[design/sesp_front.sv]
// Front end: accepts track bytes, runs the parse state and builds result bundles.
module sesp_front import sesp_pkg::*; #(
	parameter int POSITION_BITS = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          feed_valid,
	output logic          feed_ready,
	input  feed_t         feed_data,
	input  queue_status_t q_stat,
	output logic          push,
	output bundle_t       push_data
);

	phase_t                   ph_q, ph_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n, pos_inc;
	logic [DELTA_W-1:0]       dacc_q, dacc_n, dacc_new, addx;
	logic [2:0]               dcnt_q, dcnt_n, dcnt_new;
	logic [TICK_W-1:0]        pend_q, pend_n, sum_sat;
	logic [TICK_W:0]          sum;
	logic [7:0]               rs_q, rs_n, cs_q, cs_n, fdl_q, fdl_n;
	logic [TEMPO_W-1:0]       tempo_q, tempo_n, tempo_full;
	logic [POSITION_BITS-1:0] lpos_q, lpos_n;
	logic [7:0]               lstat_q, lstat_n;
	logic                     lval_q, lval_n;
	logic [6:0]               loops_q, loops_n;
	logic                     fore_q, fore_n;
	logic                     run_q, run_n;

	logic [7:0]  b;
	logic        last, accept, step, loop_ok, take_loop, eot, do_data, dsecond;
	logic [14:0] bend_full;
	logic        ev1_v, ev2_v;
	res_t        ev1, ev2, loop_res, ranout_res;

	function automatic res_t mk_res(input event_kind_t kind, input logic [3:0] ch,
		input logic [7:0] d1, input logic [7:0] d2, input logic [BEND_W-1:0] bend,
		input logic [TEMPO_W-1:0] tempo, input logic [SEEK_W-1:0] seek);
		res_t r;
		r.event_kind    = kind;
		r.channel       = ch;
		r.data_first    = d1;
		r.data_second   = d2;
		r.bend_value    = bend;
		r.delta_ticks   = '0;
		r.tempo_us      = tempo;
		r.seek_position = seek;
		r.last_result   = 1'b0;
		return r;
	endfunction

	assign b          = feed_data.byte_value;
	assign last       = feed_data.last_byte;
	assign feed_ready = !q_stat.full;
	assign accept     = feed_valid && feed_ready;
	assign step       = accept && (feed_data.command == CMD_FEED) && run_q;
	assign pos_inc    = pos_q + 1'b1;
	assign dacc_new   = {dacc_q[DELTA_W-8:0], b[6:0]};
	assign dcnt_new   = dcnt_q + 3'd1;
	assign loop_ok    = lval_q && (fore_q || (loops_q != '0));
	assign tempo_full = ({tempo_q[TEMPO_W-1:8], b} == '0) ? TEMPO_DEFAULT
		: {tempo_q[TEMPO_W-1:8], b};
	assign bend_full  = {b, 7'b0} | {7'b0, fdl_q};
	assign loop_res   = mk_res(EV_LOOPBACK, '0, '0, '0, '0, '0, SEEK_W'(lpos_q));
	assign ranout_res = mk_res(EV_RANOUT, '0, '0, '0, '0, '0, '0);

	always_comb begin
		ph_n      = ph_q;
		pos_n     = pos_inc;
		dacc_n    = dacc_q;
		dcnt_n    = dcnt_q;
		rs_n      = rs_q;
		cs_n      = cs_q;
		fdl_n     = fdl_q;
		tempo_n   = tempo_q;
		lpos_n    = lpos_q;
		lstat_n   = lstat_q;
		lval_n    = lval_q;
		loops_n   = loops_q;
		fore_n    = fore_q;
		run_n     = run_q;
		ev1_v     = 1'b0;
		ev2_v     = 1'b0;
		ev1       = ranout_res;
		ev2       = ranout_res;
		take_loop = 1'b0;
		eot       = 1'b0;
		do_data   = 1'b0;
		dsecond   = 1'b0;
		addx      = '0;

		case (ph_q)
			PH_STATUS: begin
				if (!b[7]) begin
					if (rs_q == '0) begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_BAD_STATUS, '0, b, '0, '0, '0, '0);
						run_n = 1'b0;
					end else begin
						cs_n    = rs_q;
						do_data = 1'b1;
					end
				end else begin
					cs_n = b;
					if (b < STATUS_SYS) begin
						rs_n = b;
						ph_n = PH_DATA1;
					end else if (b == STATUS_META) begin
						ph_n = PH_META;
					end else begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_BAD_STATUS, '0, b, '0, '0, '0, '0);
						run_n = 1'b0;
					end
				end
			end
			PH_DATA1: begin
				do_data = 1'b1;
			end
			PH_DATA2: begin
				do_data = 1'b1;
				dsecond = 1'b1;
			end
			PH_META: begin
				if (b == META_TEMPO) begin
					ph_n = PH_TEMPO1;
				end else if (b == META_EOT) begin
					ph_n   = PH_EOTLEN;
					dcnt_n = '0;
					eot    = last;
				end else begin
					ev1_v = 1'b1;
					ev1   = mk_res(EV_DESYNC, '0, b, '0, '0, '0, '0);
					run_n = 1'b0;
				end
			end
			PH_TEMPO1: begin
				tempo_n = {b, 16'h0};
				ph_n    = PH_TEMPO2;
			end
			PH_TEMPO2: begin
				tempo_n = {tempo_q[TEMPO_W-1:16], b, tempo_q[7:0]};
				ph_n    = PH_TEMPO3;
			end
			PH_TEMPO3: begin
				tempo_n = tempo_full;
				ph_n    = PH_DELTA;
				ev1_v   = 1'b1;
				ev1     = mk_res(EV_TEMPO, '0, '0, '0, '0, tempo_full, '0);
			end
			PH_EOTLEN: begin
				dcnt_n = dcnt_new;
				eot    = !b[7] || (dcnt_new >= DELTA_MAX_BYTES) || last;
			end
			default: begin
				ph_n = PH_DELTA;
				if (!b[7] || (dcnt_new >= DELTA_MAX_BYTES)) begin
					addx   = dacc_new;
					dacc_n = '0;
					dcnt_n = '0;
					ph_n   = PH_STATUS;
				end else begin
					dacc_n = dacc_new;
					dcnt_n = dcnt_new;
				end
			end
		endcase

		if (eot) begin
			dacc_n = '0;
			dcnt_n = '0;
			ph_n   = PH_DELTA;
			ev1_v  = 1'b1;
			if (loop_ok) begin
				take_loop = 1'b1;
				ev1       = loop_res;
			end else begin
				ev1   = mk_res(EV_END, '0, '0, '0, '0, '0, '0);
				run_n = 1'b0;
			end
		end

		if (do_data) begin
			if (!dsecond) begin
				if (cs_n[7:4] inside {ST_PROGRAM, ST_CHAN_PRESS}) begin
					ph_n = PH_DELTA;
					if (cs_n[7:4] == ST_PROGRAM) begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_PROGRAM, cs_n[3:0], b, '0, '0, '0, '0);
					end
				end else begin
					fdl_n = b;
					ph_n  = PH_DATA2;
				end
			end else begin
				ph_n = PH_DELTA;
				case (cs_n[7:4])
					ST_NOTE_OFF: begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_NOTE_OFF, cs_n[3:0], fdl_q, b, '0, '0, '0);
					end
					ST_NOTE_ON: begin
						ev1_v = 1'b1;
						ev1   = mk_res((b == '0) ? EV_NOTE_OFF : EV_NOTE_ON, cs_n[3:0],
							fdl_q, b, '0, '0, '0);
					end
					ST_CONTROL: begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_CONTROL, cs_n[3:0], fdl_q, b, '0, '0, '0);
						if (fdl_q == CC_LOOP_COUNT) begin
							fore_n  = (b >= LOOP_FOREVER);
							loops_n = (b >= LOOP_FOREVER) ? '0 : b[6:0];
						end else if (fdl_q == CC_LOOP_MARK) begin
							if (b == MARK_START) begin
								lpos_n  = pos_inc;
								lstat_n = rs_q;
								lval_n  = 1'b1;
							end else if ((b == MARK_END) && loop_ok) begin
								take_loop = 1'b1;
								ev2_v     = 1'b1;
								ev2       = loop_res;
							end
						end
					end
					ST_BEND: begin
						ev1_v = 1'b1;
						ev1   = mk_res(EV_BEND, cs_n[3:0], '0, '0, bend_full[BEND_W-1:0],
							'0, '0);
					end
					default: begin
					end
				endcase
			end
		end

		if (take_loop) begin
			if (!fore_q) begin
				loops_n = loops_q - 7'd1;
			end
			pos_n = lpos_q;
			rs_n  = lstat_q;
			ph_n  = PH_DELTA;
		end

		if (run_n && last && !take_loop) begin
			if (ph_n == PH_DELTA) begin
				addx   = dacc_n;
				dacc_n = '0;
				dcnt_n = '0;
			end
			if (ev1_v) begin
				ev2_v = 1'b1;
			end else begin
				ev1_v = 1'b1;
			end
			run_n = 1'b0;
		end

		sum     = {1'b0, pend_q} + {{(TICK_W + 1 - DELTA_W){1'b0}}, addx};
		sum_sat = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
		if (ev1_v) begin
			ev1.delta_ticks = sum_sat;
			pend_n          = '0;
		end else begin
			pend_n = sum_sat;
		end
	end

	always_comb begin
		push_data                   = '0;
		push_data.two               = ev2_v;
		push_data.res_a             = ev1;
		push_data.res_a.last_result = !ev2_v;
		push_data.res_b             = ev2;
		push_data.res_b.last_result = 1'b1;
	end

	assign push = step && ev1_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_n_reset: begin
				ph_q    <= PH_DELTA;
				pos_q   <= '0;
				dacc_q  <= '0;
				dcnt_q  <= '0;
				pend_q  <= '0;
				rs_q    <= '0;
				cs_q    <= '0;
				fdl_q   <= '0;
				tempo_q <= '0;
				lpos_q  <= '0;
				lstat_q <= '0;
				lval_q  <= 1'b0;
				loops_q <= '0;
				fore_q  <= 1'b0;
				run_q   <= 1'b1;
			end
		end else if (accept && (feed_data.command == CMD_RESTART)) begin
			ph_q    <= PH_DELTA;
			pos_q   <= '0;
			dacc_q  <= '0;
			dcnt_q  <= '0;
			pend_q  <= '0;
			rs_q    <= '0;
			cs_q    <= '0;
			fdl_q   <= '0;
			tempo_q <= '0;
			lpos_q  <= '0;
			lstat_q <= '0;
			lval_q  <= 1'b0;
			loops_q <= '0;
			fore_q  <= 1'b0;
			run_q   <= 1'b1;
		end else if (step) begin
			ph_q    <= ph_n;
			pos_q   <= pos_n;
			dacc_q  <= dacc_n;
			dcnt_q  <= dcnt_n;
			pend_q  <= pend_n;
			rs_q    <= rs_n;
			cs_q    <= cs_n;
			fdl_q   <= fdl_n;
			tempo_q <= tempo_n;
			lpos_q  <= lpos_n;
			lstat_q <= lstat_n;
			lval_q  <= lval_n;
			loops_q <= loops_n;
			fore_q  <= fore_n;
			run_q   <= run_n;
		end
	end

endmodule

[design/sesp_queue.sv]
// Short bundle queue between the parse front end and the output back end.
module sesp_queue import sesp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bundle_t       push_data,
	input  logic          pop,
	output bundle_t       pop_data,
	output queue_status_t q_stat
);

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/sesp_back.sv]
// Back end: splits bundles into single results and drives the output register.
module sesp_back import sesp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_stat,
	input  bundle_t       q_data,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res_data
);

	res_t out_q, sec_q;
	logic out_v_q, sec_v_q, load;

	assign load      = !out_v_q || res_ready;
	assign pop       = load && !sec_v_q && !q_stat.empty;
	assign res_valid = out_v_q;
	assign res_data  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_v_q) begin
				out_q <= sec_q;
			end else begin
				out_q <= q_data.res_a;
				sec_q <= q_data.res_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sec_v_q <= 1'b0;
		end else if (load) begin
			if (sec_v_q) begin
				out_v_q <= 1'b1;
				sec_v_q <= 1'b0;
			end else begin
				out_v_q <= !q_stat.empty;
				sec_v_q <= !q_stat.empty && q_data.two;
			end
		end
	end

endmodule

[design/sesp_checker.sv]
// Port-level checks for the sequence event stream parser, bound to the top level.
module sesp_checker import sesp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input res_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed or dropped while stalled");

	a_bend_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind != EV_BEND) |-> (res_data.bend_value == '0))
		else $error("bend value on a non-bend result");

	a_seek_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind != EV_LOOPBACK) |-> (res_data.seek_position == '0))
		else $error("seek position on a non-loopback result");

	a_tempo_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind == EV_TEMPO) |-> (res_data.tempo_us != '0))
		else $error("zero tempo transferred");

endmodule

bind seq_event_stream_parser_unit sesp_checker u_sesp_checker (.*);

[tb/sv/parser_event_check.sv]
`timescale 1ns / 100ps
// Track byte decoder and in-order comparison of the parser's event transfers.
module parser_event_check import sesp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  feed_valid,
	input  logic  feed_ready,
	input  feed_t feed_data,
	input  logic  res_valid,
	input  logic  res_ready,
	input  res_t  res_data,
	output int    error_count,
	output int    events_pending,
	output int    bytes_parsed,
	output int    events_seen
);

	phase_t             phase;
	logic [SEEK_W-1:0]  pos;
	logic [DELTA_W-1:0] delta_acc;
	logic [2:0]         delta_cnt;
	logic [TICK_W-1:0]  ticks;
	logic [7:0]         run_status;
	logic [7:0]         cur_status;
	logic [7:0]         data_latch;
	logic [TEMPO_W-1:0] tempo_acc;
	logic [SEEK_W-1:0]  loop_pos;
	logic [7:0]         loop_status;
	logic               loop_armed;
	logic [6:0]         loops_left;
	logic               loop_forever;
	logic               playing;
	logic               looped;
	res_t               new_events[$];
	res_t               events_due[$];

	task automatic clear_parser();
		phase = PH_DELTA;
		pos = '0;
		delta_acc = '0;
		delta_cnt = '0;
		ticks = '0;
		run_status = '0;
		cur_status = '0;
		data_latch = '0;
		tempo_acc = '0;
		loop_pos = '0;
		loop_status = '0;
		loop_armed = 1'b0;
		loops_left = '0;
		loop_forever = 1'b0;
		playing = 1'b1;
	endtask

	task automatic add_ticks(input logic [TICK_W-1:0] t);
		logic [TICK_W:0] sum;
		sum = {1'b0, ticks} + {1'b0, t};
		ticks = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
	endtask

	task automatic post_event(input event_kind_t kind, input logic [3:0] ch,
			input logic [7:0] d1, input logic [7:0] d2, input logic [BEND_W-1:0] bend,
			input logic [TEMPO_W-1:0] tempo, input logic [SEEK_W-1:0] seek);
		res_t ev;
		if (new_events.size() < 2) begin
			ev.event_kind = kind;
			ev.channel = ch;
			ev.data_first = d1;
			ev.data_second = d2;
			ev.bend_value = bend;
			ev.delta_ticks = ticks;
			ev.tempo_us = tempo;
			ev.seek_position = seek;
			ev.last_result = 1'b0;
			new_events.push_back(ev);
			ticks = '0;
		end
	endtask

	task automatic halt(input event_kind_t kind, input logic [7:0] d1);
		post_event(kind, 4'h0, d1, '0, '0, '0, '0);
		playing = 1'b0;
	endtask

	task automatic take_loop(output bit taken);
		taken = 1'b0;
		if (loop_armed && (loop_forever || loops_left != 7'd0)) begin
			if (!loop_forever)
				loops_left = loops_left - 7'd1;
			pos = loop_pos;
			run_status = loop_status;
			phase = PH_DELTA;
			post_event(EV_LOOPBACK, 4'h0, '0, '0, '0, '0, loop_pos);
			looped = 1'b1;
			taken = 1'b1;
		end
	endtask

	task automatic finish_track();
		bit taken;
		delta_acc = '0;
		delta_cnt = '0;
		phase = PH_DELTA;
		take_loop(taken);
		if (!taken)
			halt(EV_END, 8'h00);
	endtask

	task automatic control_change(input logic [3:0] ch, input logic [7:0] cc,
			input logic [7:0] val);
		bit taken;
		post_event(EV_CONTROL, ch, cc, val, '0, '0, '0);
		if (cc == CC_LOOP_COUNT) begin
			loop_forever = (val >= LOOP_FOREVER);
			loops_left = loop_forever ? 7'd0 : val[6:0];
		end else if (cc == CC_LOOP_MARK) begin
			if (val == MARK_START) begin
				loop_pos = pos;
				loop_status = run_status;
				loop_armed = 1'b1;
			end else if (val == MARK_END) begin
				take_loop(taken);
			end
		end
	endtask

	task automatic data_byte(input logic [7:0] b);
		logic [3:0]        kind;
		logic [3:0]        ch;
		logic [BEND_W-1:0] bend;
		kind = cur_status[7:4];
		ch = cur_status[3:0];
		bend = {b[6:0], 7'b0} | {6'b0, data_latch};
		if (phase != PH_DATA2) begin
			if (kind == ST_PROGRAM || kind == ST_CHAN_PRESS) begin
				phase = PH_DELTA;
				if (kind == ST_PROGRAM)
					post_event(EV_PROGRAM, ch, b, '0, '0, '0, '0);
			end else begin
				data_latch = b;
				phase = PH_DATA2;
			end
		end else begin
			phase = PH_DELTA;
			case (kind)
				ST_NOTE_OFF: post_event(EV_NOTE_OFF, ch, data_latch, b, '0, '0, '0);
				ST_NOTE_ON: post_event((b == 8'h00) ? EV_NOTE_OFF : EV_NOTE_ON, ch,
						data_latch, b, '0, '0, '0);
				ST_CONTROL: control_change(ch, data_latch, b);
				ST_BEND: post_event(EV_BEND, ch, '0, '0, bend, '0, '0);
				default: ;
			endcase
		end
	endtask

	task automatic status_byte(input logic [7:0] b);
		if (!b[7]) begin
			if (run_status == 8'h00) begin
				halt(EV_BAD_STATUS, b);
			end else begin
				cur_status = run_status;
				phase = PH_DATA1;
				data_byte(b);
			end
		end else begin
			cur_status = b;
			if (b < STATUS_SYS) begin
				run_status = b;
				phase = PH_DATA1;
			end else if (b == STATUS_META) begin
				phase = PH_META;
			end else begin
				halt(EV_BAD_STATUS, b);
			end
		end
	endtask

	task automatic decode_byte(input feed_t item);
		logic [7:0] b;
		res_t       tail;
		b = item.byte_value;
		new_events.delete();
		looped = 1'b0;
		if (item.command == CMD_RESTART) begin
			clear_parser();
			bytes_parsed++;
		end else if (playing) begin
			bytes_parsed++;
			pos = pos + 1'b1;
			case (phase)
				PH_STATUS: status_byte(b);
				PH_DATA1, PH_DATA2: data_byte(b);
				PH_META: begin
					if (b == META_TEMPO) begin
						phase = PH_TEMPO1;
					end else if (b == META_EOT) begin
						phase = PH_EOTLEN;
						delta_cnt = '0;
						if (item.last_byte)
							finish_track();
					end else begin
						halt(EV_DESYNC, b);
					end
				end
				PH_TEMPO1: begin
					tempo_acc = {b, 16'h0000};
					phase = PH_TEMPO2;
				end
				PH_TEMPO2: begin
					tempo_acc = tempo_acc | {8'h00, b, 8'h00};
					phase = PH_TEMPO3;
				end
				PH_TEMPO3: begin
					tempo_acc = tempo_acc | {16'h0000, b};
					if (tempo_acc == '0)
						tempo_acc = TEMPO_DEFAULT;
					phase = PH_DELTA;
					post_event(EV_TEMPO, 4'h0, '0, '0, '0, tempo_acc, '0);
				end
				PH_EOTLEN: begin
					delta_cnt = delta_cnt + 3'd1;
					if (!b[7] || delta_cnt >= DELTA_MAX_BYTES || item.last_byte)
						finish_track();
				end
				default: begin
					delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
					delta_cnt = delta_cnt + 3'd1;
					phase = PH_DELTA;
					if (!b[7] || delta_cnt >= DELTA_MAX_BYTES) begin
						add_ticks({4'h0, delta_acc});
						delta_acc = '0;
						delta_cnt = '0;
						phase = PH_STATUS;
					end
				end
			endcase
			if (playing && item.last_byte && !looped) begin
				if (phase == PH_DELTA) begin
					add_ticks({4'h0, delta_acc});
					delta_acc = '0;
					delta_cnt = '0;
				end
				halt(EV_RANOUT, 8'h00);
			end
			if (new_events.size() != 0) begin
				tail = new_events.pop_back();
				tail.last_result = 1'b1;
				new_events.push_back(tail);
			end
			foreach (new_events[i])
				events_due.push_back(new_events[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic compare_event(input res_t got);
		res_t want;
		if (events_due.size() == 0) begin
			$display("%0t: event transfer with none expected: expected nothing, actual 0x%h",
				$time, got);
			error_count++;
		end else begin
			want = events_due.pop_front();
			check_field("event_kind", want.event_kind, got.event_kind);
			check_field("channel", want.channel, got.channel);
			check_field("data_first", want.data_first, got.data_first);
			check_field("data_second", want.data_second, got.data_second);
			check_field("bend_value", want.bend_value, got.bend_value);
			check_field("delta_ticks", want.delta_ticks, got.delta_ticks);
			check_field("tempo_us", want.tempo_us, got.tempo_us);
			check_field("seek_position", want.seek_position, got.seek_position);
			check_field("last_result", want.last_result, got.last_result);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			events_due.delete();
			error_count = 0;
			events_pending = 0;
			bytes_parsed = 0;
			events_seen = 0;
		end else begin
			if (feed_valid && feed_ready)
				decode_byte(feed_data);
			if (res_valid && res_ready) begin
				compare_event(res_data);
				events_seen++;
			end
			events_pending = events_due.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the parser testbench: reset, track byte stimulus, output pacing and verdict.
module testbench;
	import sesp_pkg::*;

	localparam int         PARSE_TARGET  = 2000;
	localparam int         IDLE_LIMIT    = 4000;
	localparam int         HOLD_CYCLES   = 400;
	localparam logic [3:0] ST_POLY_PRESS = 4'hA;
	localparam logic [7:0] META_UNKNOWN  = 8'h01;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  feed_valid = 1'b0;
	logic  feed_ready;
	feed_t feed_data = '0;
	logic  res_valid;
	logic  res_ready = 1'b0;
	res_t  res_data;

	int         error_count;
	int         events_pending;
	int         bytes_parsed;
	int         events_seen;
	bit         hold_request = 1'b0;
	bit         quiet = 1'b0;
	int         idle_cycles = 0;
	int         tracks_sent = 0;
	logic [7:0] track_bytes[$];
	logic [7:0] gen_status;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	seq_event_stream_parser_unit dut (
		.clk,
		.arst_n,
		.feed_valid,
		.feed_ready,
		.feed_data,
		.res_valid,
		.res_ready,
		.res_data
	);

	parser_event_check event_check (
		.clk,
		.arst_n,
		.feed_valid,
		.feed_ready,
		.feed_data,
		.res_valid,
		.res_ready,
		.res_data,
		.error_count,
		.events_pending,
		.bytes_parsed,
		.events_seen
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] data_value();
		logic [7:0] v;
		v = 8'($urandom_range(0, 127));
		if ($urandom_range(0, 15) == 0)
			v[7] = 1'b1;
		return v;
	endfunction

	function automatic logic [7:0] loop_count();
		case ($urandom_range(0, 6))
			4: return LOOP_FOREVER;
			5: return 8'($urandom_range(128, 255));
			6: return 8'h00;
			default: return 8'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic send_feed(input logic cmd, input logic [7:0] value, input logic last);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			feed_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		feed_valid <= 1'b1;
		feed_data <= {cmd, value, last};
		do @(posedge clk); while (!feed_ready);
	endtask

	task automatic push_delta();
		int         len;
		logic [7:0] b;
		len = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 127));
			if (i < len - 1 || (len == 4 && $urandom_range(0, 3) == 0))
				b[7] = 1'b1;
			track_bytes.push_back(b);
		end
	endtask

	task automatic push_end_of_track();
		int len;
		track_bytes.push_back(STATUS_META);
		track_bytes.push_back(META_EOT);
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
		for (int i = 0; i < len; i++)
			track_bytes.push_back((i < len - 1) ? (8'h80 | 8'($urandom))
				: 8'($urandom_range(0, 127)));
	endtask

	task automatic push_event();
		int         pick;
		logic [3:0] ch;
		logic [3:0] kind;
		logic [7:0] st;
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		ch = 4'($urandom);
		push_delta();
		if (pick < 72) begin
			case ($urandom_range(0, 7))
				0: kind = ST_NOTE_OFF;
				1, 2: kind = ST_NOTE_ON;
				3, 4: kind = ST_CONTROL;
				5: kind = ST_PROGRAM;
				6: kind = $urandom_range(0, 1) ? ST_CHAN_PRESS : ST_POLY_PRESS;
				default: kind = ST_BEND;
			endcase
			st = {kind, ch};
			first = data_value();
			second = data_value();
			if (kind == ST_NOTE_ON && $urandom_range(0, 3) == 0)
				second = 8'h00;
			if (kind == ST_CONTROL) begin
				case ($urandom_range(0, 5))
					0: begin
						first = CC_LOOP_COUNT;
						second = loop_count();
					end
					1, 2: begin
						first = CC_LOOP_MARK;
						if ($urandom_range(0, 3) != 0)
							second = $urandom_range(0, 1) ? MARK_START : MARK_END;
					end
					default: ;
				endcase
			end
			if (st != gen_status || $urandom_range(0, 3) == 0)
				track_bytes.push_back(st);
			else
				first[7] = 1'b0;
			gen_status = st;
			track_bytes.push_back(first);
			if (kind != ST_PROGRAM && kind != ST_CHAN_PRESS)
				track_bytes.push_back(second);
		end else if (pick < 82) begin
			track_bytes.push_back(STATUS_META);
			track_bytes.push_back(META_TEMPO);
			if ($urandom_range(0, 3) == 0)
				repeat (3) track_bytes.push_back(8'h00);
			else
				repeat (3) track_bytes.push_back(8'($urandom));
		end else if (pick < 90) begin
			push_end_of_track();
		end else if (pick < 93) begin
			track_bytes.push_back(8'($urandom_range(STATUS_SYS, STATUS_META - 1)));
		end else if (pick < 96) begin
			b = 8'($urandom);
			if (b == META_TEMPO || b == META_EOT)
				b = META_UNKNOWN;
			track_bytes.push_back(STATUS_META);
			track_bytes.push_back(b);
		end else begin
			track_bytes.push_back(8'($urandom_range(0, 127)));
		end
	endtask

	task automatic build_track();
		int r;
		int cut;
		track_bytes.delete();
		gen_status = 8'h00;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			// saturate the tick count with events that report nothing
			repeat (18) begin
				track_bytes.push_back(8'hFF);
				track_bytes.push_back(8'hFF);
				track_bytes.push_back(8'hFF);
				track_bytes.push_back(8'h7F);
				track_bytes.push_back({ST_CHAN_PRESS, 4'($urandom)});
				track_bytes.push_back(8'($urandom_range(0, 127)));
			end
			push_event();
			push_end_of_track();
		end else begin
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7))
				push_event();
			if (r < 75) begin
				push_end_of_track();
			end else if (r < 90) begin
				cut = $urandom_range(1, track_bytes.size());
				while (track_bytes.size() > cut)
					void'(track_bytes.pop_back());
			end
		end
	endtask

	task automatic play_track();
		send_feed(CMD_RESTART, 8'($urandom), 1'($urandom));
		foreach (track_bytes[i])
			send_feed(CMD_FEED, track_bytes[i], i == track_bytes.size() - 1);
	endtask

	initial begin
		int rx_gap;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (quiet || rx_gap == 0) begin
				res_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					rx_gap = pick_gap();
			end else begin
				res_ready <= 1'b0;
				rx_gap--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_valid && feed_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		track_bytes = '{8'h00, {ST_CONTROL, 4'h0}, CC_LOOP_COUNT, 8'h01,
			8'h00, CC_LOOP_MARK, MARK_START,
			8'h00, CC_LOOP_MARK, MARK_END,
			8'h00, {ST_PROGRAM, 4'h2}, 8'h05,
			8'h00, {ST_BEND, 4'h1}, 8'h7F, 8'h40,
			8'h00, {ST_NOTE_ON, 4'h0}, 8'h3C, 8'h00,
			8'h00, STATUS_META, META_TEMPO, 8'h00, 8'h00, 8'h00,
			8'h83};
		play_track();
		send_feed(CMD_FEED, 8'h12, 1'b0);
		track_bytes = '{8'h00, 8'h45};
		play_track();
		track_bytes = '{8'h00, STATUS_SYS | 8'h03};
		play_track();
		track_bytes = '{8'h00, STATUS_META, META_UNKNOWN};
		play_track();

		while (bytes_parsed < PARSE_TARGET) begin
			quiet = (tracks_sent % 6 == 5);
			if (tracks_sent == 12)
				hold_request = 1'b1;
			if (tracks_sent == 20) begin
				@(negedge clk);
				feed_valid <= 1'b0;
				wait (events_pending == 0);
			end
			if ($urandom_range(0, 19) == 0) begin
				send_feed(CMD_RESTART, 8'($urandom), 1'($urandom));
				repeat ($urandom_range(1, 20))
					send_feed(($urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_FEED,
						8'($urandom), $urandom_range(0, 5) == 0);
			end else begin
				build_track();
				play_track();
			end
			tracks_sent++;
		end
		@(negedge clk);
		feed_valid <= 1'b0;
		quiet = 1'b0;

		wait (events_pending == 0);
		repeat (8) @(posedge clk);
		$display("Fed %0d tracks (%0d bytes parsed); %0d events compared in order.",
			tracks_sent, bytes_parsed, events_seen);
		$display("Tracks mixed loops, end of track, truncation, bad status, desync and stalls.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
